@@ rtl/assert_macros.svh @@
// Assertion macros shared by the rectangle sparse table RTL.
// Included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled in reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/rist_pkg.sv @@
// Package for the rectangle-intersection sparse table: sizes, types, helpers.
// No dependencies.
`default_nettype none
package rist_pkg;
   localparam int MAX_ROWS   = 32;
   localparam int MAX_COLS   = 32;
   localparam int COORD_BITS = 32;
   localparam int ROW_BITS   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_BITS   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_LEVELS = $clog2(MAX_ROWS + 1);
   localparam int COL_LEVELS = $clog2(MAX_COLS + 1);
   localparam int RL_BITS    = (ROW_LEVELS > 1) ? $clog2(ROW_LEVELS) : 1;
   localparam int CL_BITS    = (COL_LEVELS > 1) ? $clog2(COL_LEVELS) : 1;
   localparam int DIM_BITS   = 6;
   localparam int ADDR_BITS  = RL_BITS + CL_BITS + ROW_BITS + COL_BITS;
   localparam int PADDR_BITS = 3;

   localparam logic [PADDR_BITS-1:0] REG_ROWS = 3'd0;
   localparam logic [PADDR_BITS-1:0] REG_COLS = 3'd4;

   typedef struct packed {
      logic signed [31:0] lx;
      logic signed [31:0] ly;
      logic signed [31:0] hx;
      logic signed [31:0] hy;
   } rect_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_BRD_A, ST_BRD_B, ST_BWAIT, ST_BWR,
      ST_QRD, ST_QWAIT, ST_QMUL, ST_QOUT
   } state_type;

   // Table control from the sequencer for loads, the build sweep and queries.
   typedef struct packed {
      logic             wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      logic [ADDR_BITS-1:0] rd_addr;
      logic             acc_clr;
      logic             acc_en;
   } tbl_ctl_type;

   function automatic logic [ADDR_BITS-1:0] slot(input logic [RL_BITS-1:0] h,
      input logic [CL_BITS-1:0] w, input logic [ROW_BITS-1:0] i,
      input logic [COL_BITS-1:0] j);
      slot = {h, w, i, j};
   endfunction

   function automatic rect_type merge(input rect_type a, input rect_type b);
      merge.lx = (a.lx > b.lx) ? a.lx : b.lx;
      merge.ly = (a.ly > b.ly) ? a.ly : b.ly;
      merge.hx = (a.hx < b.hx) ? a.hx : b.hx;
      merge.hy = (a.hy < b.hy) ? a.hy : b.hy;
   endfunction

   function automatic logic signed [31:0] coord(input logic [31:0] raw);
      coord = 32'(signed'(raw[COORD_BITS-1:0]));
   endfunction

   // floor(log2(v)) for v >= 1, v up to 2^DIM_BITS-1.
   function automatic logic [DIM_BITS-1:0] flog2(input logic [DIM_BITS-1:0] v);
      logic [DIM_BITS-1:0] r;
      r = '0;
      for (int k = 1; k < DIM_BITS; k++) begin
         if (v[k]) r = DIM_BITS'(k);
      end
      flog2 = r;
   endfunction
endpackage
`default_nettype wire

@@ rtl/rist_table.sv @@
// Table memory with the shared merge unit and accumulator.
// Depends on rist_pkg.
`default_nettype none
module rist_table (
   input  wire logic                clock,
   input  wire rist_pkg::tbl_ctl_type ctl,
   input  wire rist_pkg::rect_type  wr_load,
   input  wire logic                wr_sel_load,
   output rist_pkg::rect_type       acc
);
   import rist_pkg::*;

   localparam int DEPTH = 2 ** ADDR_BITS;

   rect_type mem [DEPTH];
   rect_type rd_ff;
   rect_type acc_ff;
   rect_type acc_in;
   rect_type wdata;

   // one read port, registered
   always_ff @(posedge clock) begin
      rd_ff <= mem[ctl.rd_addr];
      if (ctl.wr_en) mem[ctl.wr_addr] <= wdata;
   end

   // shared merge unit: clear loads the read, enable folds it into the accumulator
   always_comb begin
      acc_in = acc_ff;
      if (ctl.acc_clr) acc_in = rd_ff;
      else if (ctl.acc_en) acc_in = merge(acc_ff, rd_ff);
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign wdata = wr_sel_load ? wr_load : acc_in;
   assign acc   = acc_ff;
endmodule
`default_nettype wire

@@ rtl/rist_ctrl.sv @@
// Sequencer for loads, table build sweep and queries.
// Depends on rist_pkg and assert_macros.svh.
`default_nettype none
module rist_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_kind,
   input  wire logic [4:0]          req_row_a,
   input  wire logic [4:0]          req_col_a,
   input  wire logic [4:0]          req_row_b,
   input  wire logic [4:0]          req_col_b,
   input  wire logic                req_last_load,
   input  wire logic [rist_pkg::DIM_BITS-1:0] rows,
   input  wire logic [rist_pkg::DIM_BITS-1:0] cols,
   input  wire logic                cfg_write,
   output rist_pkg::tbl_ctl_type    ctl,
   output logic                     wr_sel_load,
   output logic                     load_capture,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_bad,
   output logic                     rsp_take_acc
);
   import rist_pkg::*;

   state_type state_ff, state_in;
   logic ready_ff, ready_in;
   logic [RL_BITS-1:0] h_ff, h_in, lh_ff, lh_in;
   logic [CL_BITS-1:0] w_ff, w_in, lw_ff, lw_in;
   logic [ROW_BITS-1:0] i_ff, i_in, qi_ff, qi_in, qre_ff, qre_in;
   logic [COL_BITS-1:0] j_ff, j_in, qj_ff, qj_in, qce_ff, qce_in;
   logic [1:0] k_ff, k_in;
   logic bad_ff, bad_in, ldok_ff, ldok_in, last_ff, last_in, valid_ff, valid_in;
   logic [ROW_BITS-1:0] lrow_ff, lrow_in;
   logic [COL_BITS-1:0] lcol_ff, lcol_in;

   logic accept;
   logic [DIM_BITS:0] i_end, j_end;
   logic [4:0] r1, r2, c1, c2;
   logic [DIM_BITS-1:0] qh, qw;
   logic [5:0] re, ce;
   logic i_last, j_last, w_last;

   assign accept = req_valid && !req_stall;

   // query bound decoding
   always_comb begin
      r1 = (req_row_a < req_row_b) ? req_row_a : req_row_b;
      r2 = (req_row_a < req_row_b) ? req_row_b : req_row_a;
      c1 = (req_col_a < req_col_b) ? req_col_a : req_col_b;
      c2 = (req_col_a < req_col_b) ? req_col_b : req_col_a;
      qh = flog2(DIM_BITS'(r2 - r1) + 1'b1);
      qw = flog2(DIM_BITS'(c2 - c1) + 1'b1);
      re = 6'(r2) + 6'd1 - (6'd1 << qh);
      ce = 6'(c2) + 6'd1 - (6'd1 << qw);
   end

   // build sweep bounds: i + 2^h <= rows, j + 2^w <= cols
   always_comb begin
      i_end  = (DIM_BITS+1)'(rows) - ((DIM_BITS+1)'(1) << h_ff);
      j_end  = (DIM_BITS+1)'(cols) - ((DIM_BITS+1)'(1) << w_ff);
      i_last = (DIM_BITS+1)'(i_ff) >= i_end;
      j_last = (DIM_BITS+1)'(j_ff) >= j_end;
      w_last = w_ff == lw_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = req_kind ? ST_QRD : ST_LOAD;
         end
         ST_LOAD: begin
            if (!last_ff) state_in = ST_IDLE;
            else if (lh_ff == '0 && lw_ff == '0) state_in = ST_IDLE;
            else state_in = ST_BRD_A;
         end
         ST_BRD_A: state_in = ST_BRD_B;
         ST_BRD_B: state_in = ST_BWAIT;
         ST_BWAIT: state_in = ST_BWR;
         ST_BWR: begin
            if (j_last && i_last && w_last && h_ff == lh_ff) state_in = ST_IDLE;
            else state_in = ST_BRD_A;
         end
         ST_QRD: begin
            if (bad_ff) state_in = ST_QOUT;
            else if (k_ff == 2'd3) state_in = ST_QWAIT;
         end
         ST_QWAIT: state_in = ST_QMUL;
         ST_QMUL: state_in = ST_QOUT;
         ST_QOUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and counters
   always_comb begin
      h_in = h_ff; w_in = w_ff; i_in = i_ff; j_in = j_ff; k_in = k_ff;
      lh_in = lh_ff; lw_in = lw_ff; qi_in = qi_ff; qj_in = qj_ff;
      qre_in = qre_ff; qce_in = qce_ff; bad_in = bad_ff; ldok_in = ldok_ff;
      last_in = last_ff; lrow_in = lrow_ff; lcol_in = lcol_ff; ready_in = ready_ff;
      valid_in = valid_ff;
      ctl = '0;
      wr_sel_load = 1'b0;
      load_capture = 1'b0;
      rsp_take_acc = 1'b0;
      if (cfg_write) ready_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               load_capture = !req_kind;
               lrow_in = ROW_BITS'(req_row_a);
               lcol_in = COL_BITS'(req_col_a);
               ldok_in = (6'(req_row_a) < rows) && (6'(req_col_a) < cols);
               last_in = req_last_load;
               lh_in = RL_BITS'(flog2(rows));
               lw_in = CL_BITS'(flog2(cols));
               qi_in = ROW_BITS'(r1); qj_in = COL_BITS'(c1);
               qre_in = ROW_BITS'(re); qce_in = COL_BITS'(ce);
               h_in = RL_BITS'(qh); w_in = CL_BITS'(qw);
               bad_in = !ready_ff || (6'(r2) >= rows) || (6'(c2) >= cols);
               k_in = '0;
               if (!req_kind) ready_in = 1'b0;
            end
         end
         ST_LOAD: begin
            ctl.wr_en = ldok_ff;
            ctl.wr_addr = slot('0, '0, lrow_ff, lcol_ff);
            wr_sel_load = 1'b1;
            h_in = '0; w_in = CL_BITS'(1); i_in = '0; j_in = '0;
            if (lw_ff == '0) begin
               h_in = RL_BITS'(1);
               w_in = '0;
            end
            if (last_ff && lh_ff == '0 && lw_ff == '0) ready_in = 1'b1;
         end
         ST_BRD_A: begin
            if (h_ff != '0)
               ctl.rd_addr = slot(h_ff - 1'b1, w_ff, i_ff, j_ff);
            else
               ctl.rd_addr = slot(h_ff, w_ff - 1'b1, i_ff, j_ff);
         end
         ST_BRD_B: begin
            if (h_ff != '0)
               ctl.rd_addr = slot(h_ff - 1'b1, w_ff,
                  i_ff + ROW_BITS'(1 << (h_ff - 1'b1)), j_ff);
            else
               ctl.rd_addr = slot(h_ff, w_ff - 1'b1, i_ff,
                  j_ff + COL_BITS'(1 << (w_ff - 1'b1)));
            ctl.acc_clr = 1'b1;
         end
         ST_BWAIT: begin
            ctl.acc_en = 1'b1;
         end
         ST_BWR: begin
            ctl.wr_en = 1'b1;
            ctl.wr_addr = slot(h_ff, w_ff, i_ff, j_ff);
            ctl.acc_en = 1'b0;
            // write stores the held accumulator
            if (!j_last) j_in = j_ff + 1'b1;
            else begin
               j_in = '0;
               if (!i_last) i_in = i_ff + 1'b1;
               else begin
                  i_in = '0;
                  if (!w_last) w_in = w_ff + 1'b1;
                  else begin
                     w_in = '0;
                     h_in = h_ff + 1'b1;
                     if (h_ff == lh_ff) ready_in = 1'b1;
                  end
               end
            end
         end
         ST_QRD: begin
            unique case (k_ff)
               2'd0: ctl.rd_addr = slot(h_ff, w_ff, qi_ff, qj_ff);
               2'd1: ctl.rd_addr = slot(h_ff, w_ff, qre_ff, qce_ff);
               2'd2: ctl.rd_addr = slot(h_ff, w_ff, qi_ff, qce_ff);
               default: ctl.rd_addr = slot(h_ff, w_ff, qre_ff, qj_ff);
            endcase
            ctl.acc_clr = k_ff == 2'd1;
            ctl.acc_en = k_ff > 2'd1;
            k_in = k_ff + 1'b1;
            if (bad_ff) valid_in = 1'b1;
         end
         ST_QWAIT: ctl.acc_en = 1'b1;
         ST_QMUL: begin
            ctl.acc_en = 1'b1;
            rsp_take_acc = 1'b1;
            valid_in = 1'b1;
         end
         ST_QOUT: begin
            if (!rsp_stall) valid_in = 1'b0;
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = state_ff != ST_IDLE;
      rsp_valid = valid_ff;
      rsp_bad   = bad_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         valid_ff <= valid_in;
      end
      h_ff <= h_in; w_ff <= w_in; i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      lh_ff <= lh_in; lw_ff <= lw_in; qi_ff <= qi_in; qj_ff <= qj_in;
      qre_ff <= qre_in; qce_ff <= qce_in; bad_ff <= bad_in; ldok_ff <= ldok_in;
      last_ff <= last_in; lrow_ff <= lrow_in; lcol_ff <= lcol_in;
   end

`include "assert_macros.svh"
   `CHK_IMPL(a_valid_out, clock, reset, rsp_valid, state_ff == ST_QOUT, "result outside QOUT")
   `CHK_IMPL(a_no_wr_query, clock, reset, state_ff == ST_QRD, !ctl.wr_en, "write during query")
   `CHK_NEXT(a_load_clears, clock, reset, accept && !req_kind, !ready_ff, "load kept table ready")
endmodule
`default_nettype wire

@@ rtl/rect_intersect_sparse_table_2d.sv @@
// Top level: APB config regs, sequencer, table with shared merge unit, area multiply.
// Depends on rist_pkg, rist_ctrl, rist_table.
// Load: ST_LOAD writes the cell. Query: 4 reads on one memory port, merge, 32x32 area
// multiply, result held in ST_QOUT during rsp_stall; a rejected query skips the merge.
// A request is taken only in ST_IDLE. A last load builds the table. Reset clears
// control and sets both dims to 32; queries before a build are flagged bad.
`default_nettype none
module rect_intersect_sparse_table_2d (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [4:0]  req_row_a,
   input  wire logic [4:0]  req_col_a,
   input  wire logic [4:0]  req_row_b,
   input  wire logic [4:0]  req_col_b,
   input  wire logic signed [31:0] req_corner_ax,
   input  wire logic signed [31:0] req_corner_ay,
   input  wire logic signed [31:0] req_corner_bx,
   input  wire logic signed [31:0] req_corner_by,
   input  wire logic        req_last_load,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [31:0] rsp_low_x,
   output logic signed [31:0] rsp_low_y,
   output logic signed [31:0] rsp_high_x,
   output logic signed [31:0] rsp_high_y,
   output logic [63:0]      rsp_overlap_area,
   output logic             rsp_bad_query,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [rist_pkg::PADDR_BITS-1:0] paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import rist_pkg::*;

   logic [DIM_BITS-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic cfg_write;
   tbl_ctl_type ctl;
   rect_type acc, load_rect_ff, load_rect_in, res_ff, res_in;
   logic wr_sel_load, load_capture, bad, take_acc;
   logic [63:0] area_ff, area_in;
   logic [31:0] dx, dy;
   logic signed [31:0] ax, ay, bx, by;

   assign pready = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   // config registers, clamped to 1..MAX
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (cfg_write && paddr == REG_ROWS) begin
         rows_in = (pwdata[5:0] == '0) ? DIM_BITS'(1) :
            (pwdata[5:0] > DIM_BITS'(MAX_ROWS)) ? DIM_BITS'(MAX_ROWS) : pwdata[5:0];
      end
      if (cfg_write && paddr == REG_COLS) begin
         cols_in = (pwdata[5:0] == '0) ? DIM_BITS'(1) :
            (pwdata[5:0] > DIM_BITS'(MAX_COLS)) ? DIM_BITS'(MAX_COLS) : pwdata[5:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == REG_ROWS) prdata = 32'(rows_ff);
      else if (paddr == REG_COLS) prdata = 32'(cols_ff);
   end

   // load rectangle: swap corners
   always_comb begin
      ax = coord(req_corner_ax); ay = coord(req_corner_ay);
      bx = coord(req_corner_bx); by = coord(req_corner_by);
      load_rect_in = load_rect_ff;
      if (load_capture) begin
         load_rect_in.lx = (ax < bx) ? ax : bx;
         load_rect_in.hx = (ax < bx) ? bx : ax;
         load_rect_in.ly = (ay < by) ? ay : by;
         load_rect_in.hy = (ay < by) ? by : ay;
      end
   end

   // result register and area multiply (single 32x32, unsigned extents)
   always_comb begin
      res_in = res_ff;
      area_in = area_ff;
      dx = acc.hx - acc.lx;
      dy = acc.hy - acc.ly;
      if (take_acc) begin
         res_in = acc;
         area_in = '0;
         if (acc.lx < acc.hx && acc.ly < acc.hy)
            area_in = 64'(dx) * 64'(dy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DIM_BITS'(MAX_ROWS);
         cols_ff <= DIM_BITS'(MAX_COLS);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
      load_rect_ff <= load_rect_in;
      res_ff <= res_in;
      area_ff <= area_in;
   end

   rist_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_row_a(req_row_a), .req_col_a(req_col_a),
      .req_row_b(req_row_b), .req_col_b(req_col_b), .req_last_load(req_last_load),
      .rows(rows_ff), .cols(cols_ff), .cfg_write(cfg_write), .ctl(ctl),
      .wr_sel_load(wr_sel_load), .load_capture(load_capture),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_bad(bad),
      .rsp_take_acc(take_acc)
   );

   rist_table u_table (
      .clock(clock), .ctl(ctl), .wr_load(load_rect_in), .wr_sel_load(wr_sel_load),
      .acc(acc)
   );

   // bad queries report zeros
   always_comb begin
      rsp_bad_query    = bad;
      rsp_low_x        = bad ? '0 : res_ff.lx;
      rsp_low_y        = bad ? '0 : res_ff.ly;
      rsp_high_x       = bad ? '0 : res_ff.hx;
      rsp_high_y       = bad ? '0 : res_ff.hy;
      rsp_overlap_area = bad ? '0 : area_ff;
   end
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for rect_intersect_sparse_table_2d: a queue-fed driver,
// a clocked monitor with a built-in intersection predictor, and APB register writes.
// Depends on rist_pkg and the RTL top level.
`default_nettype none
module tb;
   import rist_pkg::*;

   localparam int HALF_PERIOD = 10;
   localparam int STALL_LIMIT = 600000;

   typedef struct {
      logic               kind;
      logic [4:0]         row_a, col_a, row_b, col_b;
      logic signed [31:0] ax, ay, bx, by;
      logic               last;
   } rect_item_type;

   typedef struct {
      logic signed [31:0] lx, ly, hx, hy;
      logic [63:0]        area;
      logic               bad;
   } answer_type;

   logic clock, reset;
   logic req_valid, req_stall, req_kind, req_last_load;
   logic [4:0] req_row_a, req_col_a, req_row_b, req_col_b;
   logic signed [31:0] req_corner_ax, req_corner_ay, req_corner_bx, req_corner_by;
   logic rsp_valid, rsp_stall, rsp_bad_query;
   logic signed [31:0] rsp_low_x, rsp_low_y, rsp_high_x, rsp_high_y;
   logic [63:0] rsp_overlap_area;
   logic psel, penable, pwrite, pready;
   logic [PADDR_BITS-1:0] paddr;
   logic [31:0] pwdata, prdata;

   rect_intersect_sparse_table_2d u_dut (.*);

   // predictor state: loaded cells, dimensions, build flag
   logic signed [31:0] cell_lx [MAX_ROWS][MAX_COLS];
   logic signed [31:0] cell_ly [MAX_ROWS][MAX_COLS];
   logic signed [31:0] cell_hx [MAX_ROWS][MAX_COLS];
   logic signed [31:0] cell_hy [MAX_ROWS][MAX_COLS];
   int unsigned rows_used = 32, cols_used = 32;
   bit table_built = 0;

   rect_item_type pending_items[$];
   answer_type    expected_answers[$];
   int unsigned   send_idle_pct = 10, recv_idle_pct = 80;
   int            error_count = 0;
   int            quiet_cycles = 0;

   // clock
   initial begin
      clock = 0;
      forever #HALF_PERIOD clock = ~clock;
   end

   function automatic int unsigned clamp_dim(input logic [31:0] v);
      int unsigned d;
      d = v[5:0];
      if (d < 1) d = 1;
      if (d > 32) d = 32;
      return d;
   endfunction

   // apply one accepted transfer to the predictor state
   task automatic predict_item(input rect_item_type it);
      answer_type a;
      int unsigned r1, r2, c1, c2;
      logic signed [63:0] dx, dy;
      a = '{default: '0};
      if (!it.kind) begin
         table_built = 0;
         if (it.row_a < rows_used && it.col_a < cols_used) begin
            cell_lx[it.row_a][it.col_a] = (it.ax < it.bx) ? it.ax : it.bx;
            cell_hx[it.row_a][it.col_a] = (it.ax < it.bx) ? it.bx : it.ax;
            cell_ly[it.row_a][it.col_a] = (it.ay < it.by) ? it.ay : it.by;
            cell_hy[it.row_a][it.col_a] = (it.ay < it.by) ? it.by : it.ay;
         end
         if (it.last) table_built = 1;
         return;
      end
      r1 = (it.row_a < it.row_b) ? it.row_a : it.row_b;
      r2 = (it.row_a < it.row_b) ? it.row_b : it.row_a;
      c1 = (it.col_a < it.col_b) ? it.col_a : it.col_b;
      c2 = (it.col_a < it.col_b) ? it.col_b : it.col_a;
      if (!table_built || r2 >= rows_used || c2 >= cols_used) begin
         a.bad = 1;
      end else begin
         a.lx = 32'sh80000000; a.ly = 32'sh80000000;
         a.hx = 32'sh7fffffff; a.hy = 32'sh7fffffff;
         for (int r = r1; r <= r2; r++) begin
            for (int c = c1; c <= c2; c++) begin
               if (cell_lx[r][c] > a.lx) a.lx = cell_lx[r][c];
               if (cell_ly[r][c] > a.ly) a.ly = cell_ly[r][c];
               if (cell_hx[r][c] < a.hx) a.hx = cell_hx[r][c];
               if (cell_hy[r][c] < a.hy) a.hy = cell_hy[r][c];
            end
         end
         if (a.lx < a.hx && a.ly < a.hy) begin
            dx = 64'(a.hx) - 64'(a.lx);
            dy = 64'(a.hy) - 64'(a.ly);
            a.area = 64'(dx) * 64'(dy);
         end
      end
      expected_answers.push_back(a);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0; req_kind <= 0; req_last_load <= 0;
         req_row_a <= 0; req_col_a <= 0; req_row_b <= 0; req_col_b <= 0;
         req_corner_ax <= 0; req_corner_ay <= 0; req_corner_bx <= 0; req_corner_by <= 0;
      end else if (!req_valid || !req_stall) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            rect_item_type it;
            it = pending_items.pop_front();
            req_valid <= 1; req_kind <= it.kind; req_last_load <= it.last;
            req_row_a <= it.row_a; req_col_a <= it.col_a;
            req_row_b <= it.row_b; req_col_b <= it.col_b;
            req_corner_ax <= it.ax; req_corner_ay <= it.ay;
            req_corner_bx <= it.bx; req_corner_by <= it.by;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // response stall
   always @(posedge clock) begin
      if (reset) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // monitor: predict on request transfer, check on response transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            rect_item_type it;
            it = '{req_kind, req_row_a, req_col_a, req_row_b, req_col_b, req_corner_ax,
                   req_corner_ay, req_corner_bx, req_corner_by, req_last_load};
            predict_item(it);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               report_mismatch("unexpected response", rsp_overlap_area, 0);
            end else begin
               answer_type e;
               e = expected_answers.pop_front();
               if (rsp_low_x !== e.lx) report_mismatch("low_x", rsp_low_x, e.lx);
               if (rsp_low_y !== e.ly) report_mismatch("low_y", rsp_low_y, e.ly);
               if (rsp_high_x !== e.hx) report_mismatch("high_x", rsp_high_x, e.hx);
               if (rsp_high_y !== e.hy) report_mismatch("high_y", rsp_high_y, e.hy);
               if (rsp_overlap_area !== e.area)
                  report_mismatch("overlap_area", rsp_overlap_area, e.area);
               if (rsp_bad_query !== e.bad) report_mismatch("bad_query", rsp_bad_query, e.bad);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("rect_intersect_sparse_table_2d verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic rect_item_type mk_load(input int r, input int c,
      input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] bx,
      input logic [31:0] by, input bit last);
      rect_item_type it;
      it = '{1'b0, 5'(r), 5'(c), 5'($urandom), 5'($urandom), ax, ay, bx, by, last};
      return it;
   endfunction

   function automatic rect_item_type mk_query(input int ra, input int ca, input int rb,
                                              input int cb);
      rect_item_type it;
      it = '{1'b1, 5'(ra), 5'(ca), 5'(rb), 5'(cb), $urandom, $urandom, $urandom,
             $urandom, 1'($urandom)};
      return it;
   endfunction

   // mostly overlapping corners so intersections are often non-empty
   function automatic logic [31:0] rand_coord(input bit upper);
      if ($urandom_range(9) < 3) return $urandom;
      return upper ? 32'($urandom_range(1000)) : -32'($urandom_range(1000));
   endfunction

   function automatic rect_item_type rand_load(input int r, input int c, input bit last);
      bit sx, sy;
      logic [31:0] lx, ly, hx, hy;
      sx = $urandom; sy = $urandom;
      lx = rand_coord(0); hx = rand_coord(1); ly = rand_coord(0); hy = rand_coord(1);
      return mk_load(r, c, sx ? hx : lx, sy ? hy : ly, sx ? lx : hx, sy ? ly : hy, last);
   endfunction

   task automatic csr_write(input logic [PADDR_BITS-1:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      if (addr == REG_ROWS) rows_used = clamp_dim(data);
      else cols_used = clamp_dim(data);
      table_built = 0;
   endtask

   // wait for all transfers, then for a possible rebuild to finish
   task automatic drain();
      int unsigned lv;
      while (pending_items.size() > 0 || expected_answers.size() > 0 || req_valid)
         @(posedge clock);
      lv = ($clog2(rows_used + 1)) * ($clog2(cols_used + 1));
      repeat (4 * rows_used * cols_used * lv + 200) @(posedge clock);
   endtask

   // one random phase: set dims, load the whole grid, then mostly queries
   task automatic run_phase(input logic [31:0] rows_val, input logic [31:0] cols_val,
                            input int nq);
      int unsigned n, m;
      csr_write(REG_ROWS, rows_val);
      csr_write(REG_COLS, cols_val);
      n = rows_used; m = cols_used;
      for (int r = 0; r < n; r++)
         for (int c = 0; c < m; c++)
            pending_items.push_back(rand_load(r, c, (r == n - 1) && (c == m - 1)));
      for (int q = 0; q < nq; q++) begin
         int unsigned sel;
         sel = $urandom_range(99);
         if (sel < 5)
            pending_items.push_back(rand_load($urandom_range(31), $urandom_range(31),
                                              $urandom));
         else if (sel < 15)
            pending_items.push_back(mk_query($urandom_range(31), $urandom_range(31),
                                             $urandom_range(31), $urandom_range(31)));
         else
            pending_items.push_back(mk_query($urandom_range(n - 1), $urandom_range(m - 1),
                                             $urandom_range(n - 1), $urandom_range(m - 1)));
      end
      pending_items.push_back(rand_load(0, 0, 1));
      pending_items.push_back(mk_query(0, 0, n - 1, m - 1));
      drain();
   endtask

   initial begin
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      reset = 1;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed: queries before any build
      pending_items.push_back(mk_query(0, 0, 31, 31));
      pending_items.push_back(mk_query(31, 31, 0, 0));
      drain();
      // directed: 1x2 grid, zero rows value clamps to one
      csr_write(REG_ROWS, 0);
      csr_write(REG_COLS, 2);
      pending_items.push_back(mk_load(0, 0, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                      32'h80000000, 0));
      pending_items.push_back(mk_load(0, 1, 10, 10, -5, -5, 1));
      pending_items.push_back(mk_query(0, 0, 0, 0));     // full-range area
      pending_items.push_back(mk_query(0, 1, 0, 0));     // reversed bounds
      pending_items.push_back(mk_load(0, 1, 200, 100, 100, 200, 1));
      pending_items.push_back(mk_query(0, 1, 0, 0));
      pending_items.push_back(mk_load(0, 0, 0, 0, 50, 50, 0));
      pending_items.push_back(mk_query(0, 0, 0, 1));     // not built after a load
      pending_items.push_back(mk_load(5, 5, 1, 2, 3, 4, 1)); // off-grid, still rebuilds
      pending_items.push_back(mk_query(0, 0, 0, 1));     // empty intersection
      pending_items.push_back(mk_load(0, 0, 100, 0, 100, 50, 1)); // zero-width
      pending_items.push_back(mk_query(0, 0, 0, 0));
      pending_items.push_back(mk_query(1, 0, 0, 0));     // row out of range
      pending_items.push_back(mk_query(0, 2, 0, 0));     // column out of range
      drain();

      // random phases across the three idling modes
      for (int p = 0; p < 12; p++) begin
         if (p == 4) begin send_idle_pct = 80; recv_idle_pct = 10; end
         if (p == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
         if (p == 0) run_phase(63, 1, 40);
         else if (p == 1) run_phase(1, 32, 40);
         else if (p == 5) run_phase(32, 3, 40);
         else run_phase($urandom_range(1, 8), $urandom_range(1, 8), 45);
      end

      if (error_count == 0) begin
         $display("rect_intersect_sparse_table_2d verification clean");
      end else begin
         $display("rect_intersect_sparse_table_2d verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
